>>> rtl/u16u8_pkg.sv
package u16u8_pkg;

  localparam int QueueDepthDefault = 4;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_END,
    KIND_ONE,
    KIND_TWO,
    KIND_THREE,
    KIND_PAIR
  } kind_t;

  // One decoded word: an optional flush of a held high surrogate, then the main sequence.
  typedef struct packed {
    logic        flush;
    logic [9:0]  high_bits;
    kind_t       kind;
    logic [20:0] value;
  } job_t;

  localparam logic [15:0] MaskAscii = 16'hFF80;
  localparam logic [15:0] MaskTwo   = 16'hF800;
  localparam logic [15:0] MaskSurr  = 16'hFC00;
  localparam logic [15:0] HighSurr  = 16'hD800;
  localparam logic [15:0] LowSurr   = 16'hDC00;
  localparam logic [20:0] PlaneBase = 21'h10000;

  function automatic logic [2:0] kind_count(input kind_t kind);
    logic [2:0] n;
    unique case (kind)
      KIND_NONE:  n = 3'd0;
      KIND_END:   n = 3'd1;
      KIND_ONE:   n = 3'd1;
      KIND_TWO:   n = 3'd2;
      KIND_THREE: n = 3'd3;
      KIND_PAIR:  n = 3'd4;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] enc_byte(input kind_t kind, input logic [20:0] v,
                                          input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (kind)
      KIND_ONE: b = v[7:0];
      KIND_TWO: b = (idx == 2'd0) ? {3'b110, v[10:6]} : {2'b10, v[5:0]};
      KIND_THREE: begin
        case (idx)
          2'd0:    b = {4'b1110, v[15:12]};
          2'd1:    b = {2'b10, v[11:6]};
          default: b = {2'b10, v[5:0]};
        endcase
      end
      KIND_PAIR: begin
        case (idx)
          2'd0:    b = {5'b11110, v[20:18]};
          2'd1:    b = {2'b10, v[17:12]};
          2'd2:    b = {2'b10, v[11:6]};
          default: b = {2'b10, v[5:0]};
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/u16u8_front.sv
module u16u8_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [15:0]     code_unit,
  input  logic            q_full,
  output logic            q_push,
  output u16u8_pkg::job_t q_job
);
  import u16u8_pkg::*;

  logic [9:0] held_bits;
  logic       held;
  logic [9:0] held_bits_next;
  logic       held_next;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    q_job          = '0;
    held_next      = 1'b0;
    held_bits_next = held_bits;
    if (held && ((code_unit & MaskSurr) == LowSurr)) begin
      q_job.kind  = KIND_PAIR;
      q_job.value = PlaneBase + {1'b0, held_bits, code_unit[9:0]};
    end else begin
      q_job.flush     = held;
      q_job.high_bits = held_bits;
      q_job.value     = {5'd0, code_unit};
      if (code_unit == 16'd0) begin
        q_job.kind = KIND_END;
      end else if ((code_unit & MaskAscii) == 16'd0) begin
        q_job.kind = KIND_ONE;
      end else if ((code_unit & MaskTwo) == 16'd0) begin
        q_job.kind = KIND_TWO;
      end else if ((code_unit & MaskSurr) == HighSurr) begin
        q_job.kind     = KIND_NONE;
        held_next      = 1'b1;
        held_bits_next = code_unit[9:0];
      end else begin
        q_job.kind = KIND_THREE;
      end
    end
  end

  // drop words that produce no bytes
  assign q_push = accept && (q_job.flush || (q_job.kind != KIND_NONE));

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= 1'b0;
      held_bits <= '0;
    end else if (accept) begin
      held      <= held_next;
      held_bits <= held_bits_next;
    end
  end

endmodule

>>> rtl/u16u8_fifo.sv
module u16u8_fifo #(
  parameter int DEPTH = u16u8_pkg::QueueDepthDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u16u8_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output u16u8_pkg::job_t head_job
);
  import u16u8_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head_job  = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/u16u8_back.sv
module u16u8_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  input  u16u8_pkg::job_t job,
  output logic            job_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            last_of_run,
  output logic            end_of_string
);
  import u16u8_pkg::*;

  logic [2:0]  step;
  logic [2:0]  total;
  logic [2:0]  main_idx;
  logic        in_flush;
  logic        advance;
  logic        load;
  logic        is_last;
  logic [7:0]  byte_next;
  logic [20:0] flush_value;

  assign total       = (job.flush ? 3'd3 : 3'd0) + kind_count(job.kind);
  assign in_flush    = job.flush && (step < 3'd3);
  assign main_idx    = job.flush ? (step - 3'd3) : step;
  assign flush_value = {5'd0, HighSurr | {6'd0, job.high_bits}};
  assign byte_next   = in_flush ? enc_byte(KIND_THREE, flush_value, step[1:0])
                                : enc_byte(job.kind, job.value, main_idx[1:0]);
  assign is_last     = (step == total - 3'd1);
  assign advance     = !out_valid || out_ready;
  assign load        = advance && job_valid;
  assign job_pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= byte_next;
      last_of_run   <= is_last;
      end_of_string <= !in_flush && (job.kind == KIND_END);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (advance) begin
        out_valid <= job_valid;
      end
      if (load) begin
        step <= is_last ? 3'd0 : step + 3'd1;
      end
    end
  end

endmodule

>>> rtl/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder.
// Input channel (in_valid / in_ready / code_unit) takes one 16-bit code unit
// per word. Output channel (out_valid / out_ready) delivers one UTF-8 byte
// per word with last_of_run on the final byte of each input word and
// end_of_string on the zero byte that a zero unit produces.
// A high surrogate produces no bytes until the next unit arrives; a pair
// gives four bytes, an unpaired surrogate three, so one unit yields 0 to 6.
// With the queue empty and the output free, an accepted unit is written into
// the queue at the edge that accepts it, and its first byte is then registered
// in the single output register, which gives one output byte per cycle while
// out_ready is high and the queue holds a job. The front decodes and queues;
// the input takes a new unit every cycle while the queue has room, even while
// the output is stalled.
// When the receiver holds out_ready low, the output byte holds and the
// queue fills; in_ready drops only when the queue is full.
// Reset clears the held surrogate, the queue and the output valid.
module utf16_to_utf8_transcoder #(
  parameter int QUEUE_DEPTH = u16u8_pkg::QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] code_unit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        end_of_string
);
  import u16u8_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_not_empty;
  job_t push_job;
  job_t head_job;

  u16u8_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .code_unit (code_unit),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  u16u8_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  u16u8_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (q_not_empty),
    .job           (head_job),
    .job_pop       (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run),
    .end_of_string (end_of_string)
  );

endmodule
